FILE: hw/rtl/evpv_pkg.sv
// Package for the envelope peak/valley detector.
// Shared constants, register codes and reset values; no dependencies.
package evpv_pkg;

	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int POSITION_BITS_DEF = 32;
	localparam int STEP_BITS_DEF     = 12;

	// Configuration register widths and port shape
	localparam int STEP_REG_W  = 13;
	localparam int LEVEL_REG_W = 16;
	localparam int RATIO_REG_W = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_SIZE      = 2'd0,
		REG_MIN_PEAK_LEVEL = 2'd1,
		REG_GROWTH_RATIO   = 2'd2
	} cfg_reg_t;

	localparam logic [STEP_REG_W-1:0]  STEP_RESET      = 13'd441;
	localparam logic [LEVEL_REG_W-1:0] MIN_LEVEL_RESET = 16'd0;
	localparam logic [RATIO_REG_W-1:0] RATIO_RESET     = 16'd256;

	// Block level queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Growth ratio is Q8.8
	localparam int RATIO_FRAC_BITS = 8;

endpackage

FILE: hw/rtl/evpv_in_if.sv
// Sample input channel: valid/ready handshake carrying one audio sample.
// Depends on evpv_pkg for the default width.
interface evpv_in_if #(
	parameter int SAMPLE_BITS = evpv_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          clear_search;

	modport source(output valid, sample, clear_search, input ready);
	modport sink(input valid, sample, clear_search, output ready);
endinterface

FILE: hw/rtl/evpv_out_if.sv
// Peak report channel: valid/ready handshake carrying positions and levels.
// Depends on evpv_pkg for the default widths.
interface evpv_out_if #(
	parameter int SAMPLE_BITS   = evpv_pkg::SAMPLE_BITS_DEF,
	parameter int POSITION_BITS = evpv_pkg::POSITION_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [POSITION_BITS-1:0] peak_position;
	logic [POSITION_BITS-1:0] valley_position;
	logic [SAMPLE_BITS-1:0]   peak_level;
	logic [SAMPLE_BITS-1:0]   valley_level;

	modport source(output valid, peak_position, valley_position, peak_level, valley_level,
		input ready);
	modport sink(input valid, peak_position, valley_position, peak_level, valley_level,
		output ready);
endinterface

FILE: hw/rtl/evpv_front.sv
// Front end: sample magnitude and per-block maximum, one sample per cycle
// while q_full is low. Pushes one block level (with a pending-clear flag)
// per finished block. Depends on evpv_pkg and evpv_in_if.
module evpv_front #(
	parameter int SAMPLE_BITS = evpv_pkg::SAMPLE_BITS_DEF,
	parameter int STEP_BITS   = evpv_pkg::STEP_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	evpv_in_if.sink                samples,
	input  logic [STEP_BITS:0]     step,
	input  logic                   q_full,
	output logic                   push,
	output logic [SAMPLE_BITS:0]   push_data
);

	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [SAMPLE_BITS-1:0] peak_in;
	logic [SAMPLE_BITS-1:0] new_peak;
	logic [STEP_BITS-1:0]   fill_q;
	logic [STEP_BITS-1:0]   fill_in;
	logic [STEP_BITS:0]     fill_p1;
	logic                   pend_q;
	logic                   accept;
	logic                   blk_end;
	logic                   clr;

	assign samples.ready = !q_full;
	assign accept        = samples.valid && samples.ready;
	assign clr           = samples.clear_search;

	// most negative code maps to 2^(SAMPLE_BITS-1), which still fits unsigned
	assign raw = $unsigned(samples.sample);
	assign mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

	assign peak_in  = clr ? '0 : peak_q;
	assign fill_in  = clr ? '0 : fill_q;
	assign new_peak = (mag > peak_in) ? mag : peak_in;
	assign fill_p1  = {1'b0, fill_in} + (STEP_BITS+1)'(1);
	assign blk_end  = fill_p1 >= step;

	assign push      = accept && blk_end;
	assign push_data = {pend_q | clr, new_peak};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			fill_q <= '0;
			pend_q <= 1'b0;
		end else if (accept) begin
			if (blk_end) begin
				peak_q <= '0;
				fill_q <= '0;
				pend_q <= 1'b0;
			end else begin
				peak_q <= new_peak;
				fill_q <= fill_p1[STEP_BITS-1:0];
				pend_q <= pend_q | clr;
			end
		end
	end

endmodule

FILE: hw/rtl/evpv_queue.sv
// Short FIFO of block levels between front and back end.
// Depends on evpv_pkg for the default depth.
module evpv_queue #(
	parameter int WIDTH = evpv_pkg::SAMPLE_BITS_DEF + 1,
	parameter int DEPTH = evpv_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign valid = count_q != '0;
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> valid)
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/evpv_back.sv
// Back end: three-block window search, growth test and report register.
// Retires one block level per cycle while the report register is free.
// Depends on evpv_pkg and evpv_out_if.
module evpv_back #(
	parameter int SAMPLE_BITS   = evpv_pkg::SAMPLE_BITS_DEF,
	parameter int POSITION_BITS = evpv_pkg::POSITION_BITS_DEF,
	parameter int STEP_BITS     = evpv_pkg::STEP_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	input  logic [SAMPLE_BITS:0]                 q_data,
	output logic                                 pop,
	input  logic [STEP_BITS:0]                   step,
	input  logic [evpv_pkg::LEVEL_REG_W-1:0]     min_peak_level,
	input  logic [evpv_pkg::RATIO_REG_W-1:0]     growth_ratio,
	evpv_out_if.source                           peaks
);

	localparam int LVL_W  = SAMPLE_BITS;
	localparam int POS_W  = POSITION_BITS;
	localparam int WIDE_W = (POS_W > STEP_BITS + 1) ? POS_W : STEP_BITS + 1;
	localparam int CMP_W  = (LVL_W > evpv_pkg::LEVEL_REG_W) ? LVL_W : evpv_pkg::LEVEL_REG_W;
	localparam int PROD_W = evpv_pkg::RATIO_REG_W + LVL_W;

	// search state
	logic [LVL_W-1:0] left_q, center_q, valley_q;
	logic [1:0]       seen_q;
	logic [POS_W-1:0] voff_q, woff_q, wbase_q;

	// state after an optional clear carried with the block
	logic [LVL_W-1:0] left_e, center_e, valley_e;
	logic [1:0]       seen_e;
	logic [POS_W-1:0] voff_e, woff_e, wbase_e;

	logic [LVL_W-1:0] left_d, center_d, valley_d;
	logic [1:0]       seen_d;
	logic [POS_W-1:0] voff_d, woff_d, wbase_d;

	logic [LVL_W-1:0]  level;
	logic              clr;
	logic [POS_W-1:0]  step_p;
	logic [POS_W-1:0]  vrel;
	logic              is_peak;
	logic              growth;
	logic              report;
	logic [PROD_W-1:0] rise_scaled;
	logic [PROD_W-1:0] valley_scaled;
	logic              out_valid_q;

	assign level  = q_data[LVL_W-1:0];
	assign clr    = q_data[LVL_W];
	assign step_p = POS_W'(step);
	assign pop    = q_valid && (!out_valid_q || peaks.ready);

	assign left_e   = clr ? '0 : left_q;
	assign center_e = clr ? '0 : center_q;
	assign valley_e = clr ? '0 : valley_q;
	assign seen_e   = clr ? 2'd0 : seen_q;
	assign voff_e   = clr ? '0 : voff_q;
	assign woff_e   = clr ? '0 : woff_q;
	assign wbase_e  = clr ? '0 : wbase_q;

	// (centre - valley) * 256 against ratio * valley; only meaningful when centre > valley
	assign rise_scaled   = PROD_W'(center_e - valley_e) << evpv_pkg::RATIO_FRAC_BITS;
	assign valley_scaled = PROD_W'(growth_ratio) * PROD_W'(valley_e);

	assign is_peak = (center_e > left_e) && (center_e >= level);
	assign growth  = (CMP_W'(center_e) > CMP_W'(min_peak_level)) && (center_e > valley_e)
		&& (rise_scaled > valley_scaled);
	assign report  = (seen_e == 2'd2) && is_peak && growth;

	assign vrel = (WIDE_W'(voff_e) > WIDE_W'(step)) ? (voff_e - step_p) : '0;

	always_comb begin
		left_d   = left_e;
		center_d = center_e;
		valley_d = valley_e;
		seen_d   = seen_e;
		voff_d   = voff_e;
		woff_d   = woff_e + step_p;
		wbase_d  = wbase_e;
		case (seen_e)
			2'd0: begin
				left_d   = level;
				valley_d = level;
				voff_d   = '0;
				seen_d   = 2'd1;
			end
			2'd1: begin
				center_d = level;
				seen_d   = 2'd2;
			end
			default: begin
				if (report) begin
					// restart with the block just read as left and valley
					wbase_d  = wbase_e + woff_e;
					left_d   = level;
					valley_d = level;
					voff_d   = '0;
					seen_d   = 2'd1;
					woff_d   = step_p;
				end else begin
					if (is_peak || valley_e >= center_e) begin
						valley_d = center_e;
						voff_d   = woff_e;
					end
					left_d   = center_e;
					center_d = level;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			center_q    <= '0;
			valley_q    <= '0;
			seen_q      <= 2'd0;
			voff_q      <= '0;
			woff_q      <= '0;
			wbase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				left_q   <= left_d;
				center_q <= center_d;
				valley_q <= valley_d;
				seen_q   <= seen_d;
				voff_q   <= voff_d;
				woff_q   <= woff_d;
				wbase_q  <= wbase_d;
			end
			if (pop) begin
				out_valid_q <= report;
			end else if (peaks.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && report) begin
			peaks.peak_position   <= wbase_e + woff_e - step_p;
			peaks.valley_position <= wbase_e + vrel;
			peaks.peak_level      <= center_e;
			peaks.valley_level    <= valley_e;
		end
	end

	assign peaks.valid = out_valid_q;

	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n) seen_q != 2'd3)
		else $error("window block count out of range");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && report) |=> (seen_q == 2'd1 && voff_q == '0))
		else $error("search did not restart after a report");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !peaks.ready) |-> !pop)
		else $error("block retired while a report is stalled");

endmodule

FILE: hw/rtl/envelope_peak_valley_detector.sv
// Envelope peak/valley detector, top level.
//
// Channels: samples (sink) takes one signed sample per beat with a clear_search
// flag; peaks (source) gives one beat per reported peak with peak and valley
// positions and levels. Configuration goes through cfg_we/cfg_index/cfg_data:
// step_size, min_peak_level, growth_ratio (Q8.8), written while the block is idle.
//
// Throughput: one sample per cycle while the queue is not full. The front end
// finds the block maximum and pushes one level per finished block into a
// four-entry queue; the back end retires one queued level per cycle, while the
// report register is free, through a single 16 x SAMPLE_BITS multiply.
// Report path: the level of the block on the right of the peak is written into
// the queue, then read into the report register, which drives the report beat.
// Stalls: a stalled report holds in the output register; blocks pile up in the
// queue and samples.ready drops only when the queue is full.
// Reset: registers return to their reset values and all search state is
// cleared; there is no clearing pass. Depends on evpv_pkg, evpv_in_if,
// evpv_out_if, evpv_front, evpv_queue and evpv_back.
module envelope_peak_valley_detector #(
	parameter int SAMPLE_BITS   = evpv_pkg::SAMPLE_BITS_DEF,
	parameter int POSITION_BITS = evpv_pkg::POSITION_BITS_DEF,
	parameter int STEP_BITS     = evpv_pkg::STEP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [evpv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [evpv_pkg::CFG_DATA_W-1:0]  cfg_data,
	evpv_in_if.sink                          samples,
	evpv_out_if.source                       peaks
);

	localparam int SCMP_W = (evpv_pkg::STEP_REG_W > STEP_BITS + 1) ?
		evpv_pkg::STEP_REG_W : STEP_BITS + 1;

	logic [evpv_pkg::STEP_REG_W-1:0]  step_size_q;
	logic [evpv_pkg::LEVEL_REG_W-1:0] min_peak_level_q;
	logic [evpv_pkg::RATIO_REG_W-1:0] growth_ratio_q;

	logic [SCMP_W-1:0]    step_raw;
	logic [SCMP_W-1:0]    step_max;
	logic [SCMP_W-1:0]    step_sat;
	logic [STEP_BITS:0]   step_eff;

	logic                 push;
	logic [SAMPLE_BITS:0] push_data;
	logic                 q_full;
	logic                 q_valid;
	logic                 q_pop;
	logic [SAMPLE_BITS:0] q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q      <= evpv_pkg::STEP_RESET;
			min_peak_level_q <= evpv_pkg::MIN_LEVEL_RESET;
			growth_ratio_q   <= evpv_pkg::RATIO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				evpv_pkg::REG_STEP_SIZE:      step_size_q <= cfg_data[evpv_pkg::STEP_REG_W-1:0];
				evpv_pkg::REG_MIN_PEAK_LEVEL: min_peak_level_q <= cfg_data;
				evpv_pkg::REG_GROWTH_RATIO:   growth_ratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero step acts as one; oversize step saturates at the block counter range
	assign step_raw = SCMP_W'(step_size_q);
	assign step_max = SCMP_W'(1) << STEP_BITS;
	assign step_sat = (step_raw == '0) ? SCMP_W'(1) :
		(step_raw > step_max) ? step_max : step_raw;
	assign step_eff = step_sat[STEP_BITS:0];

	evpv_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.STEP_BITS  (STEP_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.step     (step_eff),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	evpv_queue #(
		.WIDTH(SAMPLE_BITS + 1),
		.DEPTH(evpv_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	evpv_back #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.POSITION_BITS(POSITION_BITS),
		.STEP_BITS    (STEP_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_head),
		.pop           (q_pop),
		.step          (step_eff),
		.min_peak_level(min_peak_level_q),
		.growth_ratio  (growth_ratio_q),
		.peaks         (peaks)
	);

endmodule

FILE: bench/peak_report_checker.sv
// Checker for the envelope peak/valley detector: watches the sample, report and
// register-write ports, predicts every peak report and compares field by field.
// Depends on evpv_pkg, evpv_in_if and evpv_out_if.
module peak_report_checker
	import evpv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	evpv_in_if                    samples,
	evpv_out_if                   peaks,
	output int                    mismatches,
	output int                    reports_checked,
	output int                    reports_pending
);

	localparam int STEP_CAP = 1 << STEP_BITS_DEF;

	typedef struct packed {
		logic [31:0] peak_pos;
		logic [31:0] valley_pos;
		logic [15:0] peak_lvl;
		logic [15:0] valley_lvl;
	} peak_report_t;

	logic [STEP_REG_W-1:0]  step_reg;
	logic [LEVEL_REG_W-1:0] min_level_reg;
	logic [RATIO_REG_W-1:0] ratio_reg;

	int unsigned  fill;
	int unsigned  levels_held;
	logic [15:0]  run_max;
	logic [15:0]  left_lvl;
	logic [15:0]  centre_lvl;
	logic [15:0]  valley_lvl;
	logic [31:0]  valley_off;
	logic [31:0]  win_off;
	logic [31:0]  win_base;
	peak_report_t reports_due[$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		$display("%0t checker: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic clear_search_state();
		fill        = 0;
		levels_held = 0;
		run_max     = '0;
		left_lvl    = '0;
		centre_lvl  = '0;
		valley_lvl  = '0;
		valley_off  = '0;
		win_off     = '0;
		win_base    = '0;
	endtask

	function automatic logic [31:0] block_step();
		if (step_reg == 0)
			return 32'd1;
		if (step_reg > STEP_CAP)
			return 32'(STEP_CAP);
		return 32'(step_reg);
	endfunction

	function automatic bit growth_passes(input logic [15:0] pk, input logic [15:0] vl);
		logic [63:0] lhs;
		logic [63:0] rhs;
		if (pk <= min_level_reg)
			return 1'b0;
		if (pk <= vl)
			return 1'b0;
		lhs = 64'(pk - vl) << RATIO_FRAC_BITS;
		rhs = 64'(ratio_reg) * 64'(vl);
		return lhs > rhs;
	endfunction

	// One accepted sample beat through the block-max envelope and window search
	task automatic absorb_sample(input logic [15:0] s, input logic clr);
		logic [15:0]  mag;
		logic [15:0]  lvl;
		logic [31:0]  stp;
		logic [31:0]  off;
		logic [31:0]  vrel;
		bit           candidate;
		peak_report_t r;
		stp = block_step();
		mag = s[15] ? (~s) + 16'd1 : s;
		if (clr)
			clear_search_state();
		if (mag > run_max)
			run_max = mag;
		fill++;
		if (fill < stp)
			return;
		lvl     = run_max;
		run_max = '0;
		fill    = 0;
		off     = win_off;
		case (levels_held)
			0: begin
				left_lvl    = lvl;
				valley_lvl  = lvl;
				valley_off  = '0;
				levels_held = 1;
			end
			1: begin
				centre_lvl  = lvl;
				levels_held = 2;
			end
			default: begin
				candidate = centre_lvl > left_lvl && centre_lvl >= lvl;
				if (candidate && growth_passes(centre_lvl, valley_lvl)) begin
					vrel         = valley_off > stp ? valley_off - stp : 32'd0;
					r.peak_pos   = win_base + off - stp;
					r.valley_pos = win_base + vrel;
					r.peak_lvl   = centre_lvl;
					r.valley_lvl = valley_lvl;
					reports_due  = {reports_due, r};
					// search restarts on the block just read
					win_base    = win_base + off;
					left_lvl    = lvl;
					valley_lvl  = lvl;
					valley_off  = '0;
					levels_held = 1;
					win_off     = stp;
					return;
				end
				if (candidate || valley_lvl >= centre_lvl) begin
					valley_lvl = centre_lvl;
					valley_off = off;
				end
				left_lvl   = centre_lvl;
				centre_lvl = lvl;
			end
		endcase
		win_off = off + stp;
	endtask

	task automatic check_report();
		peak_report_t want;
		if (reports_due.size() == 0) begin
			report_mismatch("report beat with none due, peak_position", peaks.peak_position, 0);
			return;
		end
		want = reports_due.pop_front();
		if (peaks.peak_position !== want.peak_pos)
			report_mismatch("peak_position", peaks.peak_position, want.peak_pos);
		if (peaks.valley_position !== want.valley_pos)
			report_mismatch("valley_position", peaks.valley_position, want.valley_pos);
		if (peaks.peak_level !== want.peak_lvl)
			report_mismatch("peak_level", 32'(peaks.peak_level), 32'(want.peak_lvl));
		if (peaks.valley_level !== want.valley_lvl)
			report_mismatch("valley_level", 32'(peaks.valley_level), 32'(want.valley_lvl));
		reports_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_reg        = STEP_RESET;
			min_level_reg   = MIN_LEVEL_RESET;
			ratio_reg       = RATIO_RESET;
			clear_search_state();
			reports_due.delete();
			mismatches      = 0;
			reports_checked = 0;
			reports_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_SIZE:      step_reg      = cfg_data[STEP_REG_W-1:0];
					REG_MIN_PEAK_LEVEL: min_level_reg = cfg_data[LEVEL_REG_W-1:0];
					REG_GROWTH_RATIO:   ratio_reg     = cfg_data[RATIO_REG_W-1:0];
					default: ;
				endcase
			end
			if (samples.valid && samples.ready)
				absorb_sample(samples.sample, samples.clear_search);
			if (peaks.valid && peaks.ready)
				check_report();
			reports_pending = reports_due.size();
		end
	end

endmodule

FILE: bench/envelope_peak_valley_detector_test.sv
// Top of the envelope peak/valley detector bench: clock, reset, register writes,
// sample stimulus and report back-pressure; verdict from peak_report_checker.
// Depends on evpv_pkg, evpv_in_if, evpv_out_if and the detector RTL.
module envelope_peak_valley_detector_test;
	import evpv_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASE_ITEMS       = 125;
	localparam int RANDOM_ITEMS      = 1000;
	localparam int MAX_PHASES        = 24;
	localparam int DIRECTED_CLEAR_AT = 13;
	localparam int SETTLE_CYCLES     = 16;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int reports_checked;
	int reports_pending;

	int idle_pct;
	int stall_pct;
	int samples_sent;
	int reg_writes;
	int cur_step;
	int block_left;
	int block_level;
	int last_level;
	bit shape_high;

	int directed_step1[20] = '{0, 300, -300, 32767, -32768, 5, 5, 5, 4, 10, 3, 2000, 1000,
		1000, 1500, 1500, 1200, 0, -1, -2};
	int directed_step0[6] = '{100, -32768, 50, 32767, -32768, 1};

	evpv_in_if  samples();
	evpv_out_if peaks();

	envelope_peak_valley_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples),
		.peaks     (peaks)
	);

	peak_report_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.samples         (samples),
		.peaks           (peaks),
		.mismatches      (mismatches),
		.reports_checked (reports_checked),
		.reports_pending (reports_pending)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		peaks.ready = ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin
		#3_000_000;
		$display("envelope_peak_valley_detector_test: done, errors");
		$finish;
	end

	task automatic send_sample(input logic [15:0] s, input logic clr);
		while ($urandom_range(0, 99) < idle_pct) begin
			samples.valid = 1'b0;
			@(negedge clk);
		end
		samples.valid        = 1'b1;
		samples.sample       = s;
		samples.clear_search = clr;
		do
			@(posedge clk);
		while (!samples.ready);
		@(negedge clk);
		samples_sent++;
	endtask

	task automatic hold_until_drained();
		samples.valid = 1'b0;
		while (reports_pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		reg_writes++;
	endtask

	// Registers change only with the queue empty and the back end quiet
	task automatic configure(input logic [CFG_DATA_W-1:0] step, input logic [15:0] min_lvl,
		input logic [15:0] ratio);
		int s;
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_STEP_SIZE, step);
		write_reg(REG_MIN_PEAK_LEVEL, min_lvl);
		write_reg(REG_GROWTH_RATIO, ratio);
		s = int'(step[STEP_REG_W-1:0]);
		cur_step   = (s == 0) ? 1 : (s > (1 << STEP_BITS_DEF)) ? (1 << STEP_BITS_DEF) : s;
		block_left = 0;
	endtask

	function automatic logic [15:0] sample_at(input int amp, input bit exact);
		int mag;
		mag = exact ? amp : int'($urandom_range(0, amp));
		if ($urandom_range(0, 1))
			return 16'(-mag);
		return 16'((mag > 32767) ? 32767 : mag);
	endfunction

	// Mostly alternating low/high blocks so that windows reach the growth test
	function automatic int pick_level();
		int lvl;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				shape_high = !shape_high;
				lvl = shape_high ? int'($urandom_range(4000, 32768)) : int'($urandom_range(0, 1800));
			end
			6, 7, 8: lvl = int'($urandom_range(0, 32768));
			default: lvl = last_level;
		endcase
		last_level = lvl;
		return lvl;
	endfunction

	task automatic run_phase(input int phase);
		bit first;
		bit clr;
		case (phase)
			0: configure(16'd1, 16'd0, 16'd256);
			1: configure(16'hE003, 16'd1000, 16'd128);
			2: begin
				configure(16'd2, 16'd0, 16'd0);
				write_reg(REG_UNUSED, 16'hFFFF);
			end
			4: configure(16'd5, 16'd32768, 16'd65535);
			6: configure(16'd4, 16'd0, 16'd512);
			default: configure(16'($urandom_range(1, 6)), 16'($urandom_range(0, 4000)),
				16'($urandom_range(0, 1024)));
		endcase
		case (phase % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 59; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 59; end
			default: begin idle_pct = 14; stall_pct = 14; end
		endcase
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			if (k == PHASE_ITEMS / 2)
				hold_until_drained();
			clr = ($urandom_range(0, 149) == 0);
			if (clr)
				block_left = 0;
			first = 1'b0;
			if (block_left == 0) begin
				block_left  = cur_step;
				block_level = pick_level();
				first       = 1'b1;
			end
			block_left--;
			send_sample(sample_at(block_level, first), clr);
		end
	endtask

	initial begin
		int phase;
		int waited;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_STEP_SIZE;
		cfg_data             = '0;
		samples.valid        = 1'b0;
		samples.sample       = '0;
		samples.clear_search = 1'b0;
		peaks.ready          = 1'b0;
		idle_pct             = 0;
		stall_pct            = 0;
		samples_sent         = 0;
		reg_writes           = 0;
		cur_step             = 1;
		block_left           = 0;
		last_level           = 0;
		shape_high           = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// one sample per block: extremes, equal neighbours, zero valley, failed growth
		configure(16'd1, 16'd0, 16'd256);
		foreach (directed_step1[k])
			send_sample(16'(directed_step1[k]), (k == 0 || k == DIRECTED_CLEAR_AT));
		// step of zero acts as one; only a full-scale negative block clears the level
		configure(16'd0, 16'd32767, 16'd0);
		foreach (directed_step0[k])
			send_sample(16'(directed_step0[k]), 1'b0);

		phase = 0;
		while (phase < MAX_PHASES && samples_sent < RANDOM_ITEMS) begin
			run_phase(phase);
			phase++;
		end

		samples.valid = 1'b0;
		waited = 0;
		while (reports_pending != 0 && waited < 50000) begin
			@(negedge clk);
			waited++;
		end
		repeat (32) @(negedge clk);

		$display("covered %0d sample beats over %0d random phases, %0d register writes",
			samples_sent, phase, reg_writes);
		$display("checked %0d peak reports, zero, masked and small random steps",
			reports_checked);
		if (mismatches == 0 && reports_pending == 0)
			$display("envelope_peak_valley_detector_test: done, clean");
		else
			$display("envelope_peak_valley_detector_test: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/evpv_pkg.sv
hw/rtl/evpv_in_if.sv
hw/rtl/evpv_out_if.sv
hw/rtl/evpv_front.sv
hw/rtl/evpv_queue.sv
hw/rtl/evpv_back.sv
hw/rtl/envelope_peak_valley_detector.sv
bench/peak_report_checker.sv
bench/envelope_peak_valley_detector_test.sv
